@@ rtl/frame_sequence_gap_tracker_top_macros.svh @@
// Assertion macros shared by the checkers of the frame sequence gap tracker.
`ifndef FRAME_SEQUENCE_GAP_TRACKER_TOP_MACROS_SVH
`define FRAME_SEQUENCE_GAP_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FSGT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FSGT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/fsgt_pkg.sv @@
// Types and constants shared by the frame sequence gap tracker modules.
package fsgt_pkg;

  // Width of the low part of a sequence number that may wrap.
  localparam int LOW_BITS = 32;

  // Backward distance above which a smaller low number counts as a wrap.
  localparam logic [LOW_BITS:0] HALF_SPAN = 33'h0_8000_0000;

  // Field widths of a result word.
  localparam int SEQ_PORT_W = 64;
  localparam int DROP_W     = 64;
  localparam int EVENT_W    = 32;
  localparam int FRAME_W    = 64;
  localparam int CLASS_W    = 3;

  // Classification of one sequence number.
  typedef enum logic [CLASS_W-1:0] {
    CLS_FIRST    = 3'd0,
    CLS_IN_ORDER = 3'd1,
    CLS_GAP      = 3'd2,
    CLS_DUP      = 3'd3,
    CLS_WRAP     = 3'd4,
    CLS_REORDER  = 3'd5
  } seq_class_t;

  // Decision passed from the classifier to the state unit.
  typedef struct packed {
    seq_class_t cls;
    logic       take_seq;
  } class_ctl_t;

endpackage

@@ rtl/frame_sequence_gap_tracker_top.sv @@
// Top level of the frame sequence gap tracker with its input and result registers.
// The tracker takes one frame sequence number per word and returns one result
// word for each, classifying the number as first, in order, gap, duplicate,
// wrap or out of order, with the drops it adds and the running saturating
// totals after it. It accepts one word every clock cycle while the result side
// keeps up. A word is registered in the input register and then in the result
// register, which presents its result and holds it until it is taken. While
// the result side stalls, the block holds two words, one in each register, and
// then drops s_axis_tready. The rate is set by the loop through previous_seq
// and the totals, which the combinational classifier and the state registers
// close for each word.
// Only the low SEQ_WIDTH bits of a sequence number are used; the counters are
// kept across a new epoch, which only forgets the previous number.
module frame_sequence_gap_tracker_top
  import fsgt_pkg::*;
#(
  parameter int SEQ_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // [63:0] seq_number
  input  logic [0:0]   s_axis_tuser,   // [0] new_epoch
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata,   // [63:0] drops_added, [127:64] drop_count,
                                       // [159:128] duplicate_count,
                                       // [191:160] reorder_count, [255:192] frame_count
  output logic [2:0]   m_axis_tuser    // [2:0] seq_class
);

  logic                 in_valid;
  logic [SEQ_WIDTH-1:0] in_seq;
  logic                 in_epoch;
  logic                 move;

  logic                 have_previous;
  logic [SEQ_WIDTH-1:0] previous_seq;
  class_ctl_t           ctl;
  logic [SEQ_WIDTH-1:0] drops_added;
  logic [DROP_W-1:0]    drop_next;
  logic [EVENT_W-1:0]   duplicate_next;
  logic [EVENT_W-1:0]   reorder_next;
  logic [FRAME_W-1:0]   frames_next;

  logic                 out_valid;
  logic [255:0]         out_data;
  seq_class_t           out_class;

  // A word moves to the result register whenever that register is free or drains.
  assign move          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || move;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_seq   <= s_axis_tdata[SEQ_WIDTH-1:0];
      in_epoch <= s_axis_tuser[0];
    end
  end

  fsgt_classify #(
    .SEQ_WIDTH(SEQ_WIDTH)
  ) u_classify (
    .seq          (in_seq),
    .epoch        (in_epoch),
    .have_previous(have_previous),
    .previous_seq (previous_seq),
    .ctl          (ctl),
    .drops_added  (drops_added)
  );

  fsgt_state #(
    .SEQ_WIDTH(SEQ_WIDTH)
  ) u_state (
    .clk           (clk),
    .rst           (rst),
    .upd           (move),
    .seq           (in_seq),
    .ctl           (ctl),
    .drops_added   (drops_added),
    .have_previous (have_previous),
    .previous_seq  (previous_seq),
    .drop_next     (drop_next),
    .duplicate_next(duplicate_next),
    .reorder_next  (reorder_next),
    .frames_next   (frames_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_class <= ctl.cls;
      out_data  <= {frames_next, reorder_next, duplicate_next, drop_next,
                    SEQ_PORT_W'(drops_added)};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_class;

endmodule

@@ rtl/fsgt_classify.sv @@
// Combinational classifier: compares a sequence number against the previous one.
module fsgt_classify
  import fsgt_pkg::*;
#(
  parameter int SEQ_WIDTH = 64
) (
  input  logic [SEQ_WIDTH-1:0] seq,
  input  logic                 epoch,
  input  logic                 have_previous,
  input  logic [SEQ_WIDTH-1:0] previous_seq,
  output class_ctl_t           ctl,
  output logic [SEQ_WIDTH-1:0] drops_added
);

  logic [SEQ_WIDTH-1:0] fwd_m1;
  logic [LOW_BITS:0]    back_dist;
  logic                 both_low;
  logic                 is_equal;
  logic                 is_greater;

  // One forward difference serves both the gap size and the wrap size, since
  // the frames skipped across a wrap equal the low bits of seq - prev - 1.
  assign fwd_m1     = seq - previous_seq - SEQ_WIDTH'(1);
  assign back_dist  = {1'b0, previous_seq[LOW_BITS-1:0]} - {1'b0, seq[LOW_BITS-1:0]};
  assign both_low   = ~|seq[SEQ_WIDTH-1:LOW_BITS] && ~|previous_seq[SEQ_WIDTH-1:LOW_BITS];
  assign is_equal   = (seq == previous_seq);
  assign is_greater = (seq > previous_seq);

  // Order of the tests decides the class.
  always_comb begin
    ctl.cls      = CLS_REORDER;
    ctl.take_seq = 1'b0;
    drops_added  = '0;
    priority if (epoch || !have_previous) begin
      ctl.cls      = CLS_FIRST;
      ctl.take_seq = 1'b1;
    end else if (is_equal) begin
      ctl.cls = CLS_DUP;
    end else if (is_greater) begin
      ctl.cls      = (fwd_m1 == '0) ? CLS_IN_ORDER : CLS_GAP;
      ctl.take_seq = 1'b1;
      drops_added  = fwd_m1;
    end else if (both_low && (back_dist > HALF_SPAN)) begin
      ctl.cls      = CLS_WRAP;
      ctl.take_seq = 1'b1;
      drops_added  = SEQ_WIDTH'(fwd_m1[LOW_BITS-1:0]);
    end else begin
      ctl.cls = CLS_REORDER;
    end
  end

endmodule

@@ rtl/fsgt_state.sv @@
// Tracker state: previous number, have-previous flag and saturating counters.
module fsgt_state
  import fsgt_pkg::*;
#(
  parameter int SEQ_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 upd,
  input  logic [SEQ_WIDTH-1:0] seq,
  input  class_ctl_t           ctl,
  input  logic [SEQ_WIDTH-1:0] drops_added,
  output logic                 have_previous,
  output logic [SEQ_WIDTH-1:0] previous_seq,
  output logic [DROP_W-1:0]    drop_next,
  output logic [EVENT_W-1:0]   duplicate_next,
  output logic [EVENT_W-1:0]   reorder_next,
  output logic [FRAME_W-1:0]   frames_next
);

  logic [DROP_W-1:0]  drop_total;
  logic [EVENT_W-1:0] duplicate_total;
  logic [EVENT_W-1:0] reorder_total;
  logic [FRAME_W-1:0] frames_total;
  logic [DROP_W:0]    drop_sum;

  // Saturating updates of the running totals.
  assign drop_sum  = {1'b0, drop_total} + {1'b0, DROP_W'(drops_added)};
  assign drop_next = drop_sum[DROP_W] ? '1 : drop_sum[DROP_W-1:0];

  assign frames_next = (&frames_total) ? frames_total : frames_total + FRAME_W'(1);

  assign duplicate_next = (ctl.cls == CLS_DUP && !(&duplicate_total))
                          ? duplicate_total + EVENT_W'(1) : duplicate_total;

  assign reorder_next = (ctl.cls == CLS_REORDER && !(&reorder_total))
                        ? reorder_total + EVENT_W'(1) : reorder_total;

  // Control state, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous   <= 1'b0;
      previous_seq    <= '0;
      drop_total      <= '0;
      duplicate_total <= '0;
      reorder_total   <= '0;
      frames_total    <= '0;
    end else if (upd) begin
      have_previous   <= 1'b1;
      drop_total      <= drop_next;
      duplicate_total <= duplicate_next;
      reorder_total   <= reorder_next;
      frames_total    <= frames_next;
      if (ctl.take_seq) begin
        previous_seq <= seq;
      end
    end
  end

endmodule

@@ rtl/fsgt_checker.sv @@
// Port-level checker for the frame sequence gap tracker, bound to the top level.
`include "frame_sequence_gap_tracker_top_macros.svh"

module fsgt_checker
  import fsgt_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [255:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser
);

  logic               seen;
  logic [FRAME_W-1:0] last_frames;
  logic               out_fire;
  logic [FRAME_W-1:0] frame_count;
  logic [DROP_W-1:0]  drops_added;

  assign out_fire    = m_axis_tvalid && m_axis_tready;
  assign frame_count = m_axis_tdata[255:192];
  assign drops_added = m_axis_tdata[63:0];

  // Remember the frame count of the last word taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen        <= 1'b0;
      last_frames <= '0;
    end else if (out_fire) begin
      seen        <= 1'b1;
      last_frames <= frame_count;
    end
  end

  // Each result counts exactly one more frame, until the count saturates.
  `FSGT_ASSERT_IMP(a_frame_step, clk, rst, out_fire && !(&last_frames), frame_count == last_frames + FRAME_W'(1), "frame count did not advance by one")

  // The first result after reset counts one frame.
  `FSGT_ASSERT_IMP(a_first_frame, clk, rst, out_fire && !seen, frame_count == FRAME_W'(1), "first frame count is not one")

  // Only gaps and wraps add drops, and a gap always adds some.
  `FSGT_ASSERT_IMP(a_drop_class, clk, rst, m_axis_tvalid && (drops_added != '0), (m_axis_tuser == CLS_GAP) || (m_axis_tuser == CLS_WRAP), "drops added outside a gap or wrap")
  `FSGT_ASSERT_IMP(a_gap_nonzero, clk, rst, m_axis_tvalid && (m_axis_tuser == CLS_GAP), drops_added != '0, "gap with no drops added")

  // A stalled result holds.
  `FSGT_ASSERT_NXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind frame_sequence_gap_tracker_top fsgt_checker u_fsgt_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

@@ bench/frame_sequence_gap_tracker_top_tb.sv @@
// Self-checking testbench for the frame sequence gap tracker top level.
module frame_sequence_gap_tracker_top_tb;
  import fsgt_pkg::*;

  localparam int SEQ_W = 64;
  localparam logic [63:0] SEQ_MASK = (SEQ_W == 64) ? '1 : ((64'd1 << SEQ_W) - 64'd1);
  localparam logic [63:0] LOW_MAX = 64'h0000_0000_ffff_ffff;
  localparam logic [63:0] HALF_WRAP = 64'h0000_0000_8000_0000;
  localparam int REPORT_DEPTH = 256;

  // One expected result word.
  typedef struct {
    seq_class_t  cls;
    logic [63:0] drops_added;
    logic [63:0] drop_count;
    logic [31:0] duplicate_count;
    logic [31:0] reorder_count;
    logic [63:0] frame_count;
  } seq_report_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;   // [63:0] seq_number
  logic [0:0]   s_axis_tuser = '0;   // [0] new_epoch
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [255:0] m_axis_tdata;        // [63:0] drops_added, [127:64] drop_count,
                                     // [159:128] duplicate_count,
                                     // [191:160] reorder_count, [255:192] frame_count
  logic [2:0]   m_axis_tuser;        // [2:0] seq_class

  // Tracker state as the bench sees it.
  logic        seen_previous;
  logic [63:0] last_seq;
  logic [63:0] drops_sum;
  logic [31:0] dups_sum;
  logic [31:0] reorders_sum;
  logic [63:0] frames_sum;

  // Expected results in flight, kept as a ring with running write and read counts.
  seq_report_t report_ring [REPORT_DEPTH];
  int report_wr = 0;
  int report_rd = 0;
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_left = 0;
  logic [63:0] seq_cursor = '0;

  frame_sequence_gap_tracker_top #(
    .SEQ_WIDTH(SEQ_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  // Clock.
  initial begin
    forever #6 clk = ~clk;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #(12 * 500000);
    $display("TEST FAILED");
    $finish;
  end

  // Classifies one sequence number and advances the bench copy of the state.
  function automatic seq_report_t predict_report(input logic [63:0] raw_seq,
                                                 input logic epoch);
    seq_report_t r;
    logic [63:0] seq;
    logic [64:0] sum;
    seq = raw_seq & SEQ_MASK;
    r.drops_added = '0;
    if (frames_sum != '1) frames_sum = frames_sum + 64'd1;
    if (epoch || !seen_previous) begin
      seen_previous = 1'b1;
      last_seq = seq;
      r.cls = CLS_FIRST;
    end else if (seq == last_seq) begin
      if (dups_sum != '1) dups_sum = dups_sum + 32'd1;
      r.cls = CLS_DUP;
    end else if (seq > last_seq) begin
      r.drops_added = seq - last_seq - 64'd1;
      r.cls = (r.drops_added == 0) ? CLS_IN_ORDER : CLS_GAP;
      last_seq = seq;
    end else if (last_seq <= LOW_MAX && seq <= LOW_MAX && (last_seq - seq) > HALF_WRAP) begin
      r.drops_added = (LOW_MAX - last_seq) + seq;
      r.cls = CLS_WRAP;
      last_seq = seq;
    end else begin
      if (reorders_sum != '1) reorders_sum = reorders_sum + 32'd1;
      r.cls = CLS_REORDER;
    end
    // Drop total saturates; drops_added is reported in full regardless.
    sum = {1'b0, drops_sum} + {1'b0, r.drops_added};
    drops_sum = sum[64] ? '1 : sum[63:0];
    r.drop_count = drops_sum;
    r.duplicate_count = dups_sum;
    r.reorder_count = reorders_sum;
    r.frame_count = frames_sum;
    return r;
  endfunction

  // Predict a result for every accepted input word.
  always @(posedge clk) begin
    if (rst) begin
      seen_previous <= 1'b0;
      last_seq <= '0;
      drops_sum <= '0;
      dups_sum <= '0;
      reorders_sum <= '0;
      frames_sum <= '0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      report_ring[report_wr % REPORT_DEPTH] = predict_report(s_axis_tdata, s_axis_tuser[0]);
      report_wr++;
    end
  end

  // Compare every accepted result word with the oldest prediction.
  always @(posedge clk) begin
    seq_report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (report_wr == report_rd) begin
        $error("unexpected result word: seq_class %0d", m_axis_tuser);
        mismatch_count++;
      end else begin
        want = report_ring[report_rd % REPORT_DEPTH];
        report_rd++;
        if (m_axis_tuser !== want.cls) begin
          $error("seq_class: expected %0d, got %0d", want.cls, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tdata[63:0] !== want.drops_added) begin
          $error("drops_added: expected %0h, got %0h", want.drops_added,
                 m_axis_tdata[63:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[127:64] !== want.drop_count) begin
          $error("drop_count: expected %0h, got %0h", want.drop_count,
                 m_axis_tdata[127:64]);
          mismatch_count++;
        end
        if (m_axis_tdata[159:128] !== want.duplicate_count) begin
          $error("duplicate_count: expected %0h, got %0h", want.duplicate_count,
                 m_axis_tdata[159:128]);
          mismatch_count++;
        end
        if (m_axis_tdata[191:160] !== want.reorder_count) begin
          $error("reorder_count: expected %0h, got %0h", want.reorder_count,
                 m_axis_tdata[191:160]);
          mismatch_count++;
        end
        if (m_axis_tdata[255:192] !== want.frame_count) begin
          $error("frame_count: expected %0h, got %0h", want.frame_count,
                 m_axis_tdata[255:192]);
          mismatch_count++;
        end
      end
    end
  end

  // Result side: random stalls, or a long hold-off counted down here.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_off_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one word, with an occasional idle gap, and waits until it is taken.
  task automatic send_word(input logic [63:0] seq, input logic epoch);
    int gap;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= seq;
    s_axis_tuser <= epoch;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (report_wr != report_rd) @(posedge clk);
  endtask

  // First item, in order, duplicate, gap, out of order, and a new epoch on a repeat.
  task automatic test_basic_classes();
    send_word(64'd5, 1'b0);
    send_word(64'd6, 1'b0);
    send_word(64'd6, 1'b0);
    send_word(64'd10, 1'b0);
    send_word(64'd8, 1'b0);
    send_word(64'd10, 1'b1);
    send_word(64'd0, 1'b1);
  endtask

  // Wrap from the maximum onto zero, wrap with a skip, the exact half distance and wide numbers.
  task automatic test_wrap_boundaries();
    send_word(64'h0000_0000_ffff_ffff, 1'b1);
    send_word(64'h0000_0000_0000_0000, 1'b0);
    send_word(64'h0000_0000_ffff_fff0, 1'b1);
    send_word(64'h0000_0000_0000_0010, 1'b0);
    send_word(64'h0000_0000_8000_0000, 1'b1);
    send_word(64'h0000_0000_0000_0000, 1'b0);
    send_word(64'h0000_0000_8000_0001, 1'b1);
    send_word(64'h0000_0000_0000_0000, 1'b0);
    send_word(64'h0000_0001_0000_0005, 1'b1);
    send_word(64'h0000_0000_0000_0003, 1'b0);
  endtask

  // Two huge gaps drive the drop total into saturation.
  task automatic test_drop_saturation();
    send_word(64'd0, 1'b1);
    send_word(64'hffff_ffff_ffff_ffff, 1'b0);
    send_word(64'd0, 1'b1);
    send_word(64'hffff_ffff_ffff_ffff, 1'b0);
    send_word(64'hffff_ffff_ffff_ffff, 1'b0);
    send_word(64'hffff_ffff_ffff_fffe, 1'b0);
  endtask

  // Mostly plausible streams with random content, plus epochs and noise.
  task automatic test_random_stream(input int count);
    int pick;
    logic epoch;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      epoch = 1'b0;
      if (pick < 45) begin
        seq_cursor = seq_cursor + 64'd1;
      end else if (pick < 60) begin
        seq_cursor = seq_cursor + 64'($urandom_range(1, 50));
      end else if (pick < 68) begin
        // Repeat the current number.
      end else if (pick < 76) begin
        seq_cursor = seq_cursor - 64'($urandom_range(1, 20));
      end else if (pick < 84) begin
        seq_cursor = {32'd0, 32'hffff_ff00 + 32'($urandom_range(255))};
        epoch = 1'b1;
      end else if (pick < 88) begin
        // Small number, which wraps when the stream sits near the 32-bit top.
        seq_cursor = 64'($urandom_range(100));
      end else if (pick < 94) begin
        seq_cursor = {$urandom, $urandom};
        epoch = 1'b1;
      end else begin
        seq_cursor = {$urandom, $urandom};
      end
      send_word(seq_cursor, epoch);
    end
  endtask

  // The result side holds off for a long time while words keep coming.
  task automatic test_result_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_left = 300;
    test_random_stream(60);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_classes();
    test_wrap_boundaries();
    test_drop_saturation();

    send_idle_pct = 20;
    recv_idle_pct = 59;
    test_random_stream(300);
    send_idle_pct = 59;
    recv_idle_pct = 20;
    test_random_stream(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(300);

    test_result_backpressure();

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && report_wr == report_rd) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
